// File: hw/rtl/ycc2rgb_pkg.sv
package ycc2rgb_pkg;

  // field widths of the packed input word
  localparam int LUMA_W   = 10;
  localparam int CHROMA_W = 10;
  localparam int ALPHA_W  = 12;
  localparam int HALF_W   = 32;
  localparam int BYTE_W   = 8;

  // bit positions inside one half
  localparam int LUMA_LO   = 0;
  localparam int CHROMA_LO = 10;
  localparam int ALPHA_LO  = 20;

  // signed width of every Q16 product and sum
  localparam int ACC_W  = 29;
  localparam int FRAC_W = 16;

  // scaled code widths
  localparam int YV_W = 17;
  localparam int CV_W = 17;
  localparam int AV_W = 14;

  // offsets of the scaled codes
  localparam logic signed [YV_W-1:0] Y_OFS = 17'sd4096;
  localparam logic signed [CV_W-1:0] C_OFS = 17'sd32768;
  localparam logic signed [AV_W-1:0] A_OFS = 14'sd16;

  // Q16 coefficients
  localparam logic signed [ACC_W-1:0] K_Y     = 29'sd299;
  localparam logic signed [ACC_W-1:0] K_RV    = 29'sd461;
  localparam logic signed [ACC_W-1:0] K_BU    = 29'sd543;
  localparam logic signed [ACC_W-1:0] K_GB    = 29'sd55;
  localparam logic signed [ACC_W-1:0] K_GR    = 29'sd137;
  localparam logic signed [ACC_W-1:0] K_ALPHA = 29'sd18204;

  localparam logic [ACC_W-FRAC_W-1:0] BYTE_MAX = 13'd255;

  // one converted pixel
  typedef struct packed {
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] g;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] a;
  } rgba_t;

  // drop the Q16 fraction, clamp to 0..255
  function automatic logic [BYTE_W-1:0] sat_byte(input logic signed [ACC_W-1:0] acc);
    logic [BYTE_W-1:0] res;
    if (acc <= 0) begin
      res = '0;
    end else if (acc[ACC_W-1:FRAC_W] > BYTE_MAX) begin
      res = {BYTE_W{1'b1}};
    end else begin
      res = acc[FRAC_W+BYTE_W-1:FRAC_W];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/ycc2rgb_if.sv
// input request: one packed pixel pair
interface ycc2rgb_in_if
  import ycc2rgb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] first_half;
  logic [HALF_W-1:0] second_half;

  modport source (output valid, output first_half, output second_half, input ready);
  modport sink   (input valid, input first_half, input second_half, output ready);
endinterface

// output request: two rgba pixels
interface ycc2rgb_out_if
  import ycc2rgb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red_first;
  logic [BYTE_W-1:0] green_first;
  logic [BYTE_W-1:0] blue_first;
  logic [BYTE_W-1:0] alpha_first;
  logic [BYTE_W-1:0] red_second;
  logic [BYTE_W-1:0] green_second;
  logic [BYTE_W-1:0] blue_second;
  logic [BYTE_W-1:0] alpha_second;

  modport source (output valid, output red_first, output green_first, output blue_first,
                  output alpha_first, output red_second, output green_second,
                  output blue_second, output alpha_second, input ready);
  modport sink   (input valid, input red_first, input green_first, input blue_first,
                  input alpha_first, input red_second, input green_second,
                  input blue_second, input alpha_second, output ready);
endinterface

// File: hw/rtl/ycc2rgb_lane.sv
module ycc2rgb_lane
  import ycc2rgb_pkg::*;
(
  input  logic                clk,
  input  logic                load,
  input  logic [LUMA_W-1:0]   luma,
  input  logic [ALPHA_W-1:0]  alpha,
  input  logic [CHROMA_W-1:0] cb,
  input  logic [CHROMA_W-1:0] cr,
  output rgba_t               pix
);

  logic signed [YV_W-1:0]  yv;
  logic signed [CV_W-1:0]  bv;
  logic signed [CV_W-1:0]  rv;
  logic signed [AV_W-1:0]  av;

  logic signed [ACC_W-1:0] ys_r, rr_r, gb_r, gr_r, bb_r, aa_r;
  logic signed [ACC_W-1:0] r_sum, g_sum, b_sum;

  // scale 10-bit codes to 16 bits and remove offsets, also from the 12-bit alpha
  assign yv = $signed({1'b0, luma, 6'b0}) - Y_OFS;
  assign bv = $signed({1'b0, cb, 6'b0}) - C_OFS;
  assign rv = $signed({1'b0, cr, 6'b0}) - C_OFS;
  assign av = $signed({2'b0, alpha}) - A_OFS;

  // coefficient products, registered
  always_ff @(posedge clk) begin
    if (load) begin
      ys_r <= ACC_W'(yv) * K_Y;
      rr_r <= ACC_W'(rv) * K_RV;
      gb_r <= ACC_W'(bv) * K_GB;
      gr_r <= ACC_W'(rv) * K_GR;
      bb_r <= ACC_W'(bv) * K_BU;
      aa_r <= ACC_W'(av) * K_ALPHA;
    end
  end

  // color sums
  assign r_sum = ys_r + rr_r;
  assign g_sum = ys_r - gb_r - gr_r;
  assign b_sum = ys_r + bb_r;

  // truncate and saturate
  assign pix.r = sat_byte(r_sum);
  assign pix.g = sat_byte(g_sum);
  assign pix.b = sat_byte(b_sum);
  assign pix.a = sat_byte(aa_r);

endmodule

// File: hw/rtl/ycc2rgb_merge.sv
module ycc2rgb_merge
  import ycc2rgb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pix_valid,
  input  rgba_t         pix_first,
  input  rgba_t         pix_second,
  output logic          load_ok,
  ycc2rgb_out_if.source out_pix
);

  logic  out_valid_r;
  rgba_t first_r, second_r;

  // output register may load when empty or being drained
  assign load_ok = !out_valid_r || out_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_ok) begin
      out_valid_r <= pix_valid;
    end
  end

  // pixel pair payload
  always_ff @(posedge clk) begin
    if (load_ok && pix_valid) begin
      first_r  <= pix_first;
      second_r <= pix_second;
    end
  end

  assign out_pix.valid        = out_valid_r;
  assign out_pix.red_first    = first_r.r;
  assign out_pix.green_first  = first_r.g;
  assign out_pix.blue_first   = first_r.b;
  assign out_pix.alpha_first  = first_r.a;
  assign out_pix.red_second   = second_r.r;
  assign out_pix.green_second = second_r.g;
  assign out_pix.blue_second  = second_r.b;
  assign out_pix.alpha_second = second_r.a;

endmodule

// File: hw/rtl/ycbcra422_10bit_to_rgba.sv
// channel | dir | payload
// --------+-----+--------------------------------------------------------
// in_pix  | in  | first_half[32] (a1,cb,y1), second_half[32] (a2,cr,y2)
// out_pix | out | red/green/blue/alpha _first and _second, 8 bits each
//
// one pixel pair per clock while the output is not stalled; a request
// passes the lane product registers, then the merged output register.
// two lanes, one per pixel, share the chroma pair of the request.
// rst_n synchronous, active low, clears the valid flags only.
// a stalled output keeps its pair; the input takes a new request while a
// bubble sits in the product stage.
module ycbcra422_10bit_to_rgba
  import ycc2rgb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ycc2rgb_in_if.sink    in_pix,
  ycc2rgb_out_if.source out_pix
);

  logic  prod_valid_r;
  logic  load_ok;
  logic  take;
  rgba_t pix_first, pix_second;

  // product stage advances when empty or when the output takes it
  assign in_pix.ready = !prod_valid_r || load_ok;
  assign take         = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (in_pix.ready) begin
      prod_valid_r <= in_pix.valid;
    end
  end

  // first pixel lane
  ycc2rgb_lane u_lane_first (
    .clk   (clk),
    .load  (take),
    .luma  (in_pix.first_half[LUMA_LO +: LUMA_W]),
    .alpha (in_pix.first_half[ALPHA_LO +: ALPHA_W]),
    .cb    (in_pix.first_half[CHROMA_LO +: CHROMA_W]),
    .cr    (in_pix.second_half[CHROMA_LO +: CHROMA_W]),
    .pix   (pix_first)
  );

  // second pixel lane
  ycc2rgb_lane u_lane_second (
    .clk   (clk),
    .load  (take),
    .luma  (in_pix.second_half[LUMA_LO +: LUMA_W]),
    .alpha (in_pix.second_half[ALPHA_LO +: ALPHA_W]),
    .cb    (in_pix.first_half[CHROMA_LO +: CHROMA_W]),
    .cr    (in_pix.second_half[CHROMA_LO +: CHROMA_W]),
    .pix   (pix_second)
  );

  // merge both lanes into the output register
  ycc2rgb_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (prod_valid_r),
    .pix_first  (pix_first),
    .pix_second (pix_second),
    .load_ok    (load_ok),
    .out_pix    (out_pix)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ycc2rgb_pkg::*;

  localparam int CLK_HIGH        = 4;
  localparam int CLK_LOW         = 4;
  localparam int RESET_CYCLES    = 2;
  localparam int PHASE_ITEMS     = 410;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT  = 1000;

  // Q16 conversion constants, BT.709 limited range
  localparam longint Q16_ONE       = 65536;
  localparam longint Q16_LUMA      = 299;
  localparam longint Q16_R_FROM_CR = 461;
  localparam longint Q16_B_FROM_CB = 543;
  localparam longint Q16_G_FROM_CB = 55;
  localparam longint Q16_G_FROM_CR = 137;
  localparam longint Q16_ALPHA     = 18204;
  localparam longint LUMA_BLACK    = 4096;
  localparam longint CHROMA_MID    = 32768;
  localparam longint ALPHA_BLACK   = 16;

  // idle percentages per phase: none, sender, receiver, both
  localparam int SEND_IDLE  [4] = '{0, 47, 0, 38};
  localparam int RECV_STALL [4] = '{0, 0, 47, 38};

  // interesting 10-bit and 12-bit codes around black, white and mid scale
  localparam logic [LUMA_W-1:0] CODE_EDGES [12] = '{
    10'd0, 10'd1, 10'd63, 10'd64, 10'd65, 10'd512,
    10'd939, 10'd940, 10'd941, 10'd960, 10'd961, 10'd1023
  };
  localparam logic [ALPHA_W-1:0] ALPHA_EDGES [8] = '{
    12'd0, 12'd15, 12'd16, 12'd17, 12'd933, 12'd934, 12'd935, 12'd4095
  };

  typedef struct packed {
    rgba_t first;
    rgba_t second;
  } rgba_pair_t;

  typedef struct packed {
    logic [HALF_W-1:0] first_half;
    logic [HALF_W-1:0] second_half;
    logic              typed;
    rgba_t             exp_first;
    rgba_t             exp_second;
  } stim_row_t;

  localparam rgba_t RGBA_ZERO = '0;
  localparam rgba_t RGBA_FULL = '1;

  // directed requests: halves are {alpha, chroma, luma}
  localparam stim_row_t DIRECTED_ROWS [16] = '{
    // black with neutral chroma and transparent alpha
    '{{12'd16, 10'd512, 10'd64}, {12'd16, 10'd512, 10'd64}, 1'b1, RGBA_ZERO, RGBA_ZERO},
    // peak white, opaque
    '{{12'd4095, 10'd512, 10'd940}, {12'd4095, 10'd512, 10'd940}, 1'b1,
      RGBA_FULL, RGBA_FULL},
    // super-white saturates
    '{{12'd4095, 10'd512, 10'd1023}, {12'd4095, 10'd512, 10'd1023}, 1'b1,
      RGBA_FULL, RGBA_FULL},
    // below black saturates to zero
    '{{12'd0, 10'd512, 10'd0}, {12'd0, 10'd512, 10'd0}, 1'b1, RGBA_ZERO, RGBA_ZERO},
    // black pixel next to white pixel
    '{{12'd16, 10'd512, 10'd64}, {12'd4095, 10'd512, 10'd940}, 1'b1,
      RGBA_ZERO, RGBA_FULL},
    '{32'h0000_0000, 32'h0000_0000, 1'b0, RGBA_ZERO, RGBA_ZERO},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, RGBA_ZERO, RGBA_ZERO},
    // strong chroma in every corner
    '{{12'd2048, 10'd0, 10'd512}, {12'd2048, 10'd0, 10'd512}, 1'b0, RGBA_ZERO, RGBA_ZERO},
    '{{12'd2048, 10'd1023, 10'd512}, {12'd2048, 10'd1023, 10'd512}, 1'b0,
      RGBA_ZERO, RGBA_ZERO},
    '{{12'd2048, 10'd0, 10'd512}, {12'd2048, 10'd1023, 10'd512}, 1'b0,
      RGBA_ZERO, RGBA_ZERO},
    '{{12'd2048, 10'd1023, 10'd512}, {12'd2048, 10'd0, 10'd512}, 1'b0,
      RGBA_ZERO, RGBA_ZERO},
    // alpha around the top and bottom of its range
    '{{12'd934, 10'd512, 10'd502}, {12'd935, 10'd512, 10'd502}, 1'b0, RGBA_ZERO, RGBA_ZERO},
    '{{12'd15, 10'd512, 10'd502}, {12'd17, 10'd512, 10'd502}, 1'b0, RGBA_ZERO, RGBA_ZERO},
    // alternating bit patterns
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, RGBA_ZERO, RGBA_ZERO},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, RGBA_ZERO, RGBA_ZERO},
    // nominal chroma extremes with near-limit luma
    '{{12'd933, 10'd64, 10'd1}, {12'd17, 10'd960, 10'd1022}, 1'b0, RGBA_ZERO, RGBA_ZERO}
  };

  logic clk = 1'b0;
  logic rst_n;

  ycc2rgb_in_if  pix_in ();
  ycc2rgb_out_if pix_out ();

  ycbcra422_10bit_to_rgba uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_in),
    .out_pix(pix_out)
  );

  rgba_pair_t pending_pairs [$];
  int         mismatch_count = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_off_req   = 0;

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  // truncate a Q16 sum toward zero and clamp to one byte
  function automatic logic [BYTE_W-1:0] clamp_q16(input longint acc);
    longint whole;
    if (acc <= 0) begin
      return '0;
    end
    whole = acc / Q16_ONE;
    if (whole > 255) begin
      return '1;
    end
    return whole[BYTE_W-1:0];
  endfunction

  // one pixel from its half word and the shared scaled chroma
  function automatic rgba_t convert_pixel_rgba(input logic [HALF_W-1:0] word,
                                               input longint cb_scaled,
                                               input longint cr_scaled);
    longint luma_code;
    longint alpha_code;
    longint luma_term;
    rgba_t  px;
    luma_code  = longint'(word[LUMA_LO +: LUMA_W]);
    alpha_code = longint'(word[ALPHA_LO +: ALPHA_W]);
    luma_term  = (luma_code * 64 - LUMA_BLACK) * Q16_LUMA;
    px.r = clamp_q16(luma_term + cr_scaled * Q16_R_FROM_CR);
    px.g = clamp_q16(luma_term - cb_scaled * Q16_G_FROM_CB - cr_scaled * Q16_G_FROM_CR);
    px.b = clamp_q16(luma_term + cb_scaled * Q16_B_FROM_CB);
    px.a = clamp_q16((alpha_code - ALPHA_BLACK) * Q16_ALPHA);
    return px;
  endfunction

  // both pixels of a request, cb from the first half and cr from the second
  function automatic rgba_pair_t convert_pair(input logic [HALF_W-1:0] first_half,
                                              input logic [HALF_W-1:0] second_half);
    longint     cb_scaled;
    longint     cr_scaled;
    rgba_pair_t pair;
    cb_scaled   = longint'(first_half[CHROMA_LO +: CHROMA_W]) * 64 - CHROMA_MID;
    cr_scaled   = longint'(second_half[CHROMA_LO +: CHROMA_W]) * 64 - CHROMA_MID;
    pair.first  = convert_pixel_rgba(first_half, cb_scaled, cr_scaled);
    pair.second = convert_pixel_rgba(second_half, cb_scaled, cr_scaled);
    return pair;
  endfunction

  // raw words, nominal video range, or codes near the range limits
  function automatic logic [HALF_W-1:0] random_half();
    logic [LUMA_W-1:0]   luma;
    logic [CHROMA_W-1:0] chroma;
    logic [ALPHA_W-1:0]  alpha;
    int                  pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      return $urandom();
    end
    if (pick < 85) begin
      luma   = LUMA_W'($urandom_range(940, 64));
      chroma = CHROMA_W'($urandom_range(960, 64));
      alpha  = ALPHA_W'($urandom_range(934, 16));
    end else begin
      luma   = CODE_EDGES[$urandom_range(11)];
      chroma = CODE_EDGES[$urandom_range(11)];
      alpha  = ALPHA_EDGES[$urandom_range(7)];
    end
    return {alpha, chroma, luma};
  endfunction

  // offer one request after a random gap, log its pixels once accepted
  task automatic offer_pair(input logic [HALF_W-1:0] first_half,
                            input logic [HALF_W-1:0] second_half,
                            input logic              typed,
                            input rgba_pair_t        typed_pair);
    rgba_pair_t want;
    want = typed ? typed_pair : convert_pair(first_half, second_half);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid       <= 1'b1;
    pix_in.first_half  <= first_half;
    pix_in.second_half <= second_half;
    @(posedge clk);
    while (!pix_in.ready) begin
      @(posedge clk);
    end
    pending_pairs.push_back(want);
  endtask

  task automatic check_byte(input string field, input logic [BYTE_W-1:0] want,
                            input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // sender side
  initial begin : source_side
    rgba_pair_t none;
    none = '0;
    rst_n              <= 1'b0;
    pix_in.valid       <= 1'b0;
    pix_in.first_half  <= '0;
    pix_in.second_half <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests, no idling
    for (int row = 0; row < 16; row++) begin
      offer_pair(DIRECTED_ROWS[row].first_half, DIRECTED_ROWS[row].second_half,
                 DIRECTED_ROWS[row].typed,
                 {DIRECTED_ROWS[row].exp_first, DIRECTED_ROWS[row].exp_second});
    end

    // random requests through each idling mix
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      if (phase == 0 || phase == 3) begin
        hold_off_req++;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        offer_pair(random_half(), random_half(), 1'b0, none);
      end
    end
    pix_in.valid <= 1'b0;

    // drain and let any stray result show up
    while (pending_pairs.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ycbcra422_10bit_to_rgba: match");
    end else begin
      $display("ycbcra422_10bit_to_rgba: mismatch");
    end
    $finish;
  end

  // receiver side: random stalls, plus a long hold-off on demand
  initial begin : sink_side
    int served;
    served = 0;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (served != hold_off_req) begin
        served++;
        pix_out.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare results in order, watchdog on handshake activity
  always @(posedge clk) begin : result_check
    rgba_pair_t want;
    int         quiet_cycles;
    if (rst_n) begin
      if (pix_out.valid && pix_out.ready) begin
        if (pending_pairs.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_count++;
        end else begin
          want = pending_pairs.pop_front();
          check_byte("red_first", want.first.r, pix_out.red_first);
          check_byte("green_first", want.first.g, pix_out.green_first);
          check_byte("blue_first", want.first.b, pix_out.blue_first);
          check_byte("alpha_first", want.first.a, pix_out.alpha_first);
          check_byte("red_second", want.second.r, pix_out.red_second);
          check_byte("green_second", want.second.g, pix_out.green_second);
          check_byte("blue_second", want.second.b, pix_out.blue_second);
          check_byte("alpha_second", want.second.a, pix_out.alpha_second);
        end
      end
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("ycbcra422_10bit_to_rgba: mismatch");
          $finish;
        end
      end
    end else begin
      quiet_cycles = 0;
    end
  end

endmodule
